FILE: src/assert_macros.svh
// Assertion macros used by the FIFO unit's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the cycle after.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/fqrn_pkg.sv
// Types, constants and helper functions shared by the FIFO unit's modules.
package fqrn_pkg;

   localparam int DEPTH  = 16;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;
   localparam int OCC_W  = 5;
   localparam int OP_W   = 2;
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
   localparam logic [DATA_W-1:0] MOST_NEG  = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [OP_W-1:0] {
      OP_ENQ = 2'd0,
      OP_DEQ = 2'd1,
      OP_RFN = 2'd2,
      OP_NOP = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_DEQ_WAIT,
      S_SCAN,
      S_SHIFT,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      RD_HEAD,
      RD_NEXT1,
      RD_NEXT2
   } rd_sel_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_MOST_NEG,
      RES_RDATA
   } res_sel_type;

   typedef struct packed {
      logic        capture;
      logic        enq_write;
      logic        shift_write;
      rd_sel_type  rd_sel;
      logic        pos_clear;
      logic        pos_advance;
      logic        head_advance;
      logic        count_dec;
      logic        res_load;
      status_type  res_status;
      res_sel_type res_sel;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   empty;
      logic   full;
      logic   negative;
      logic   last;
      logic   out_free;
   } stat_type;

   // Next slot of the circular store.
   function automatic logic [ADDR_W-1:0] slot_inc(input logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] nxt;
      if (addr == ADDR_W'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = addr + ADDR_W'(1);
      end
      return nxt;
   endfunction

   // Slot that lies off places past head; the sum stays below twice the depth.
   function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] head,
                                                  input logic [CNT_W-1:0]  off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

FILE: src/fqrn_dp.sv
// Datapath of the FIFO unit: entry store, pointers, result and output registers.
module fqrn_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [fqrn_pkg::OP_W-1:0]        req_operation,
   input  logic signed [fqrn_pkg::DATA_W-1:0] req_value_in,
   input  logic                             csr_write_enable,
   input  logic [fqrn_pkg::CAP_W-1:0]       csr_write_data,
   input  fqrn_pkg::cmd_type                cmd,
   output fqrn_pkg::stat_type               stat,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic signed [fqrn_pkg::DATA_W-1:0] rsp_value_out,
   output logic [fqrn_pkg::OCC_W-1:0]       rsp_occupancy
);

   logic [fqrn_pkg::DATA_W-1:0] entries_mem [fqrn_pkg::DEPTH];

   fqrn_pkg::op_type             op_ff;
   logic [fqrn_pkg::DATA_W-1:0]  val_ff;
   logic [fqrn_pkg::ADDR_W-1:0]  head_ff, head_in;
   logic [fqrn_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [fqrn_pkg::CAP_W-1:0]   cap_ff;
   logic [fqrn_pkg::CNT_W-1:0]   pos_ff;
   logic [fqrn_pkg::ADDR_W-1:0]  slot_ff;
   logic [fqrn_pkg::DATA_W-1:0]  rdata_ff;
   fqrn_pkg::status_type         res_status_ff;
   logic [fqrn_pkg::DATA_W-1:0]  res_value_ff;
   logic                         rsp_valid_ff;
   fqrn_pkg::status_type         rsp_status_ff;
   logic [fqrn_pkg::DATA_W-1:0]  rsp_value_ff;
   logic [fqrn_pkg::OCC_W-1:0]   rsp_occ_ff;

   logic [fqrn_pkg::ADDR_W-1:0]  rd_addr;
   logic [fqrn_pkg::ADDR_W-1:0]  wr_addr;
   logic [fqrn_pkg::DATA_W-1:0]  wr_data;
   logic                         wr_en;
   logic [fqrn_pkg::CMP_W-1:0]   cap_eff;
   logic [fqrn_pkg::DATA_W-1:0]  res_value;

   // Capacity above the store depth saturates to the depth.
   always_comb begin
      if (fqrn_pkg::CMP_W'(cap_ff) > fqrn_pkg::CMP_W'(fqrn_pkg::DEPTH)) begin
         cap_eff = fqrn_pkg::CMP_W'(fqrn_pkg::DEPTH);
      end else begin
         cap_eff = fqrn_pkg::CMP_W'(cap_ff);
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         fqrn_pkg::RD_NEXT1: rd_addr = fqrn_pkg::slot_inc(slot_ff);
         fqrn_pkg::RD_NEXT2: rd_addr = fqrn_pkg::slot_inc(fqrn_pkg::slot_inc(slot_ff));
         default:            rd_addr = head_ff;
      endcase
   end

   assign wr_en   = cmd.enq_write | cmd.shift_write;
   assign wr_addr = cmd.enq_write ? fqrn_pkg::slot_add(head_ff, count_ff) : slot_ff;
   assign wr_data = cmd.enq_write ? val_ff : rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= entries_mem[rd_addr];
   end

   always_comb begin
      head_in  = cmd.head_advance ? fqrn_pkg::slot_inc(head_ff) : head_ff;
      count_in = count_ff;
      if (cmd.enq_write) begin
         count_in = count_ff + fqrn_pkg::CNT_W'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - fqrn_pkg::CNT_W'(1);
      end
   end

   always_comb begin
      case (cmd.res_sel)
         fqrn_pkg::RES_MOST_NEG: res_value = fqrn_pkg::MOST_NEG;
         fqrn_pkg::RES_RDATA:    res_value = rdata_ff;
         default:                res_value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= fqrn_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= fqrn_pkg::op_type'(req_operation);
         val_ff <= req_value_in;
      end
      if (cmd.pos_clear) begin
         pos_ff  <= '0;
         slot_ff <= head_ff;
      end else if (cmd.pos_advance) begin
         pos_ff  <= pos_ff + fqrn_pkg::CNT_W'(1);
         slot_ff <= fqrn_pkg::slot_inc(slot_ff);
      end
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_value_ff  <= res_value;
      end
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_occ_ff    <= fqrn_pkg::OCC_W'(count_ff);
      end
   end

   assign stat.op       = op_ff;
   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (fqrn_pkg::CMP_W'(count_ff) >= cap_eff);
   assign stat.negative = rdata_ff[fqrn_pkg::DATA_W-1];
   assign stat.last     = ((fqrn_pkg::CNT_W+1)'(pos_ff) + (fqrn_pkg::CNT_W+1)'(1))
                          >= (fqrn_pkg::CNT_W+1)'(count_ff);
   assign stat.out_free = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

FILE: src/fqrn_ctrl.sv
// Controller of the FIFO unit: sequences each operation over the datapath.
module fqrn_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fqrn_pkg::stat_type stat,
   output fqrn_pkg::cmd_type  cmd
);

   fqrn_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fqrn_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      req_ready        = 1'b0;
      cmd.capture      = 1'b0;
      cmd.enq_write    = 1'b0;
      cmd.shift_write  = 1'b0;
      cmd.rd_sel       = fqrn_pkg::RD_HEAD;
      cmd.pos_clear    = 1'b0;
      cmd.pos_advance  = 1'b0;
      cmd.head_advance = 1'b0;
      cmd.count_dec    = 1'b0;
      cmd.res_load     = 1'b0;
      cmd.res_status   = fqrn_pkg::ST_OK;
      cmd.res_sel      = fqrn_pkg::RES_ZERO;
      cmd.out_load     = 1'b0;

      unique case (state_ff)
         fqrn_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = fqrn_pkg::S_DECIDE;
            end
         end
         fqrn_pkg::S_DECIDE: begin
            unique case (stat.op) inside
               fqrn_pkg::OP_ENQ: begin
                  cmd.res_load = 1'b1;
                  if (stat.full) begin
                     cmd.res_status = fqrn_pkg::ST_FULL;
                  end else begin
                     cmd.enq_write = 1'b1;
                  end
                  state_in = fqrn_pkg::S_FINISH;
               end
               fqrn_pkg::OP_DEQ, fqrn_pkg::OP_RFN: begin
                  if (stat.empty) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = fqrn_pkg::ST_EMPTY;
                     cmd.res_sel    = fqrn_pkg::RES_MOST_NEG;
                     state_in       = fqrn_pkg::S_FINISH;
                  end else if (stat.op == fqrn_pkg::OP_DEQ) begin
                     state_in = fqrn_pkg::S_DEQ_WAIT;
                  end else begin
                     cmd.pos_clear = 1'b1;
                     state_in      = fqrn_pkg::S_SCAN;
                  end
               end
               default: begin
                  cmd.res_load = 1'b1;
                  state_in     = fqrn_pkg::S_FINISH;
               end
            endcase
         end
         fqrn_pkg::S_DEQ_WAIT: begin
            cmd.res_load     = 1'b1;
            cmd.res_sel      = fqrn_pkg::RES_RDATA;
            cmd.head_advance = 1'b1;
            cmd.count_dec    = 1'b1;
            state_in         = fqrn_pkg::S_FINISH;
         end
         fqrn_pkg::S_SCAN: begin
            cmd.rd_sel = fqrn_pkg::RD_NEXT1;
            if (stat.negative) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = fqrn_pkg::RES_RDATA;
               state_in     = fqrn_pkg::S_SHIFT;
            end else if (stat.last) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = fqrn_pkg::ST_NOTFOUND;
               state_in       = fqrn_pkg::S_FINISH;
            end else begin
               cmd.pos_advance = 1'b1;
            end
         end
         fqrn_pkg::S_SHIFT: begin
            cmd.rd_sel = fqrn_pkg::RD_NEXT2;
            if (stat.last) begin
               cmd.count_dec = 1'b1;
               state_in      = fqrn_pkg::S_FINISH;
            end else begin
               cmd.shift_write = 1'b1;
               cmd.pos_advance = 1'b1;
            end
         end
         fqrn_pkg::S_FINISH: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = fqrn_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = fqrn_pkg::S_IDLE;
         end
      endcase
   end

endmodule

FILE: src/fifo_with_remove_first_negative_unit.sv
// Top level of the bounded FIFO unit with remove-first-negative.
//
//   channel   ports                                   direction
//   req       req_valid/req_ready, operation, value   in
//   rsp       rsp_valid/rsp_ready, status, value,     out
//             occupancy
//   csr       csr_write_enable, csr_write_data        in (capacity)
//
// One transaction is handled at a time. Enqueue, an ignored code and an empty
// queue go from the decide state straight to the finish state; dequeue passes
// through a read-wait state between them. Remove-first-negative scans the
// entries from the head and closes the gap after a negative one: the scan
// and the gap closing step one entry per cycle through the single registered
// read port of the entry store.
// Reset clears head, count, capacity (to 16) and the pending result; the store
// needs no clearing. A stalled rsp holds its result; the next req transaction
// is still taken and worked on, and only its final load waits for the slot.

`include "assert_macros.svh"

module fifo_with_remove_first_negative_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [fqrn_pkg::OP_W-1:0]          req_operation,
   input  logic signed [fqrn_pkg::DATA_W-1:0] req_value_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic signed [fqrn_pkg::DATA_W-1:0] rsp_value_out,
   output logic [fqrn_pkg::OCC_W-1:0]         rsp_occupancy,
   input  logic                               csr_write_enable,
   input  logic [fqrn_pkg::CAP_W-1:0]         csr_write_data
);

   fqrn_pkg::cmd_type  cmd;
   fqrn_pkg::stat_type stat;

   // Conditions watched by the checks below.
   logic occ_ok;
   logic empty_shown;
   logic empty_ok;
   logic full_shown;

   // Sequence each transaction: decide, then a read wait or a scan and shift if needed, then finish.
   fqrn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the entries, pointers and the output register.
   fqrn_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_value_in     (req_value_in),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_value_out    (rsp_value_out),
      .rsp_occupancy    (rsp_occupancy)
   );

   assign occ_ok      = (rsp_occupancy <= fqrn_pkg::OCC_W'(fqrn_pkg::DEPTH));
   assign empty_shown = rsp_valid && (rsp_status == fqrn_pkg::ST_EMPTY);
   assign empty_ok    = (rsp_value_out == fqrn_pkg::MOST_NEG);
   assign full_shown  = rsp_valid && (rsp_status == fqrn_pkg::ST_FULL);

   // Occupancy reported never exceeds the store depth.
   `ASSERT_IMPLY(a_occ_bound, rsp_valid, occ_ok, "occupancy above depth")

   // An empty report always carries the most negative value.
   `ASSERT_IMPLY(a_empty_value, empty_shown, empty_ok, "empty result with wrong value")

   // A full report carries zero.
   `ASSERT_IMPLY(a_full_value, full_shown, rsp_value_out == '0, "full result with nonzero value")

   // After a transaction is taken, req_ready drops so that no other is taken on top of it.
   `ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "req taken while busy")

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the bounded FIFO unit with remove-first-negative.
`timescale 1ns / 100ps

module tb;

   // Long receiver hold-off, counted in the receiver's own process.
   localparam int HOLDOFF_CYCLES = 300;
   // Watchdog: cycles in a row with no transaction on either channel.
   localparam int STALL_LIMIT    = 3000;
   // Worst single transaction is a remove-first-negative over a full store.
   localparam int SETTLE_CYCLES  = fqrn_pkg::DEPTH + 8;
   localparam int NUM_PHASES     = 8;

   // One result transaction as the unit should produce it.
   typedef struct {
      fqrn_pkg::status_type        status;
      logic [fqrn_pkg::DATA_W-1:0] value;
      logic [fqrn_pkg::OCC_W-1:0]  occupancy;
   } reply_type;

   // Shadow copy of the queue: predicts each reply and checks the unit against it.
   class fifo_shadow_type;
      logic [fqrn_pkg::DATA_W-1:0] slots [fqrn_pkg::DEPTH];
      int                          head;
      int                          count;
      int                          capacity;
      reply_type                   awaited_replies[$];
      int                          errors;

      function new();
         head     = 0;
         count    = 0;
         capacity = fqrn_pkg::CAP_RESET;
         errors   = 0;
      endfunction

      function void set_capacity(int cap);
         capacity = cap;
      endfunction

      // Apply one request to the shadow queue and return the reply it causes.
      function reply_type apply_operation(fqrn_pkg::op_type op,
                                          logic [fqrn_pkg::DATA_W-1:0] val);
         reply_type r;
         int        limit;
         int        pos;
         int        i;
         limit    = (capacity > fqrn_pkg::DEPTH) ? fqrn_pkg::DEPTH : capacity;
         r.status = fqrn_pkg::ST_OK;
         r.value  = '0;
         case (op)
            fqrn_pkg::OP_ENQ: begin
               if (count >= limit) begin
                  r.status = fqrn_pkg::ST_FULL;
               end else begin
                  slots[(head + count) % fqrn_pkg::DEPTH] = val;
                  count++;
               end
            end
            fqrn_pkg::OP_DEQ: begin
               if (count == 0) begin
                  r.status = fqrn_pkg::ST_EMPTY;
                  r.value  = fqrn_pkg::MOST_NEG;
               end else begin
                  r.value = slots[head];
                  head    = (head + 1) % fqrn_pkg::DEPTH;
                  count--;
               end
            end
            fqrn_pkg::OP_RFN: begin
               if (count == 0) begin
                  r.status = fqrn_pkg::ST_EMPTY;
                  r.value  = fqrn_pkg::MOST_NEG;
               end else begin
                  pos = count;
                  for (i = 0; i < count; i++) begin
                     if (pos == count &&
                         slots[(head + i) % fqrn_pkg::DEPTH][fqrn_pkg::DATA_W-1]) begin
                        pos = i;
                     end
                  end
                  if (pos == count) begin
                     r.status = fqrn_pkg::ST_NOTFOUND;
                  end else begin
                     r.value = slots[(head + pos) % fqrn_pkg::DEPTH];
                     for (i = pos; i + 1 < count; i++) begin
                        slots[(head + i) % fqrn_pkg::DEPTH] =
                           slots[(head + i + 1) % fqrn_pkg::DEPTH];
                     end
                     count--;
                  end
               end
            end
            default: begin
            end
         endcase
         r.occupancy = fqrn_pkg::OCC_W'(count);
         return r;
      endfunction

      function void note_request(fqrn_pkg::op_type op, logic [fqrn_pkg::DATA_W-1:0] val);
         awaited_replies.push_back(apply_operation(op, val));
      endfunction

      function void check_reply(logic [1:0] status, logic [fqrn_pkg::DATA_W-1:0] value,
                                logic [fqrn_pkg::OCC_W-1:0] occ);
         reply_type want;
         if (awaited_replies.size() == 0) begin
            $error("unexpected result: status %0d value %h occupancy %0d", status, value, occ);
            errors++;
            return;
         end
         want = awaited_replies.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
         end
         if (value !== want.value) begin
            $error("value_out: expected %h, actual %h", want.value, value);
            errors++;
         end
         if (occ !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy, occ);
            errors++;
         end
      endfunction
   endclass

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic [fqrn_pkg::OP_W-1:0]          req_operation;
   logic signed [fqrn_pkg::DATA_W-1:0] req_value_in;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic [1:0]                         rsp_status;
   logic signed [fqrn_pkg::DATA_W-1:0] rsp_value_out;
   logic [fqrn_pkg::OCC_W-1:0]         rsp_occupancy;
   logic                               csr_write_enable;
   logic [fqrn_pkg::CAP_W-1:0]         csr_write_data;

   fifo_shadow_type shadow = new();

   // Idling knobs, in percent of cycles; the main sequence sets them per phase.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   // Raised by the main sequence; the receiver drops it once it starts holding off.
   bit holdoff_req    = 1'b0;
   int idle_cycles    = 0;

   fifo_with_remove_first_negative_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_value_in     (req_value_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_value_out    (rsp_value_out),
      .rsp_occupancy    (rsp_occupancy),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sample both channels at the rising edge. Check the reply first so that a
   // request taken on the same edge never lines up against an older result.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         shadow.check_reply(rsp_status, rsp_value_out, rsp_occupancy);
      end
      if (!reset && req_valid && req_ready) begin
         shadow.note_request(fqrn_pkg::op_type'(req_operation), req_value_in);
      end
   end

   // Watchdog: end the run if no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: stall at random at the falling edge; on request, hold off for a
   // long stretch so the unit's result slot stays full and it pushes back on its input.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_req) begin
            holdoff_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLDOFF_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Offer one request; start and end at a falling edge. Valid stays high after
   // acceptance so the next call can reuse it without a glitch; drop it when idling.
   task automatic send_item(input fqrn_pkg::op_type op,
                            input logic [fqrn_pkg::DATA_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value_in  <= val;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Write the capacity register; call only while nothing is in flight.
   task automatic write_capacity(input int cap);
      csr_write_enable <= 1'b1;
      csr_write_data   <= fqrn_pkg::CAP_W'(cap);
      shadow.set_capacity(cap);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Stop offering and wait until every predicted reply has been seen.
   task automatic drain_replies(input int extra);
      req_valid <= 1'b0;
      while (shadow.awaited_replies.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
      @(negedge clock);
   endtask

   // Mostly random words, with extremes and a tunable share of negative values.
   function automatic logic [fqrn_pkg::DATA_W-1:0] pick_value(input int neg_pct);
      logic [fqrn_pkg::DATA_W-1:0] v;
      v = $urandom();
      case ($urandom_range(15))
         0: v = fqrn_pkg::MOST_NEG;
         1: v = {1'b0, {(fqrn_pkg::DATA_W-1){1'b1}}};
         2: v = '0;
         3: v = '1;
         default: v[fqrn_pkg::DATA_W-1] = ($urandom_range(99) < neg_pct);
      endcase
      return v;
   endfunction

   function automatic fqrn_pkg::op_type pick_op(input int enq_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < enq_pct) begin
         return fqrn_pkg::OP_ENQ;
      end
      roll = $urandom_range(99);
      if (roll < 40) begin
         return fqrn_pkg::OP_DEQ;
      end else if (roll < 88) begin
         return fqrn_pkg::OP_RFN;
      end
      return fqrn_pkg::OP_NOP;
   endfunction

   // Random traffic in bursts that alternate between filling and draining the
   // queue, each burst with its own share of negative values.
   task automatic send_random(input int num_items);
      int k;
      int enq_pct;
      int neg_pct;
      enq_pct = 75;
      neg_pct = 45;
      for (k = 0; k < num_items; k++) begin
         if (k % 32 == 0) begin
            enq_pct = ((k / 32) % 2 == 0) ? 75 : 25;
            neg_pct = 5 + 40 * $urandom_range(2);
         end
         send_item(pick_op(enq_pct), pick_value(neg_pct));
      end
   endtask

   initial begin
      int phase_caps  [NUM_PHASES];
      int phase_items [NUM_PHASES];
      int p;
      phase_caps  = '{31, 1, 0, 16, 0, 17, 2, 16};
      phase_items = '{110, 80, 40, 60, 110, 110, 80, 110};

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = fqrn_pkg::OP_ENQ;
      req_value_in     = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_capacity(16);

      // Directed: empty queue, ignored code, extremes, search miss, removal from
      // the middle and from the tail, then drain down to empty again.
      send_item(fqrn_pkg::OP_DEQ, '0);
      send_item(fqrn_pkg::OP_RFN, '0);
      send_item(fqrn_pkg::OP_NOP, '1);
      send_item(fqrn_pkg::OP_ENQ, 32'h7FFF_FFFF);
      send_item(fqrn_pkg::OP_ENQ, 32'h0000_0000);
      send_item(fqrn_pkg::OP_ENQ, 32'h0000_0001);
      send_item(fqrn_pkg::OP_RFN, '0);
      send_item(fqrn_pkg::OP_ENQ, fqrn_pkg::MOST_NEG);
      send_item(fqrn_pkg::OP_ENQ, 32'h1234_5678);
      send_item(fqrn_pkg::OP_ENQ, 32'hFFFF_FFFF);
      send_item(fqrn_pkg::OP_NOP, 32'h5555_5555);
      send_item(fqrn_pkg::OP_RFN, '0);
      send_item(fqrn_pkg::OP_RFN, '0);
      send_item(fqrn_pkg::OP_DEQ, '0);
      send_item(fqrn_pkg::OP_ENQ, 32'hAAAA_AAAA);
      send_item(fqrn_pkg::OP_ENQ, 32'h5555_5555);
      send_item(fqrn_pkg::OP_RFN, '0);
      send_item(fqrn_pkg::OP_DEQ, '0);
      send_item(fqrn_pkg::OP_DEQ, '0);
      send_item(fqrn_pkg::OP_DEQ, '0);
      send_item(fqrn_pkg::OP_DEQ, '0);
      send_item(fqrn_pkg::OP_DEQ, '0);
      drain_replies(4);

      // Random phases: rotate capacity settings (saturating, tiny, zero) and
      // idling modes. Each phase ends with the sender paused until all replies
      // are in, so the register is only written while the unit is idle.
      for (p = 0; p < NUM_PHASES; p++) begin
         if (p == 4) begin
            write_capacity($urandom_range(31));
         end else begin
            write_capacity(phase_caps[p]);
         end
         case (p % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 73;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 73;
            end
            default: begin
               send_idle_pct  = 14;
               recv_stall_pct = 14;
            end
         endcase
         // Hold off the receiver once while requests keep coming.
         if (p == 3) begin
            holdoff_req = 1'b1;
         end
         send_random(phase_items[p]);
         drain_replies(4);
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      drain_replies(SETTLE_CYCLES);

      if (shadow.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
